@@ hw/rtl/b64sc_pkg.sv @@
// Shared types, constants and alphabet functions for the Base64 stream codec.
// No dependencies; used by base64_stream_codec_unit.
package b64sc_pkg;

   localparam logic [7:0] PadChar = 8'h3D;
   localparam int unsigned MaxResults = 4;
   localparam int unsigned CountWidth = $clog2(MaxResults + 1);

   typedef struct packed {
      logic       alpha;
      logic       pad;
      logic [5:0] value;
   } char_code_type;

   function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
      logic [7:0] c;
      if (s < 6'd26) begin
         c = 8'h41 + {2'b00, s};
      end else if (s < 6'd52) begin
         c = 8'h61 + {2'b00, s - 6'd26};
      end else if (s < 6'd62) begin
         c = 8'h30 + {2'b00, s - 6'd52};
      end else if (s == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

   function automatic char_code_type char_decode(input logic [7:0] c);
      char_code_type r;
      r = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.alpha = 1'b1;
         r.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.alpha = 1'b1;
         r.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.alpha = 1'b1;
         r.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r.alpha = 1'b1;
         r.value = 6'd62;
      end else if (c == 8'h2F) begin
         r.alpha = 1'b1;
         r.value = 6'd63;
      end else if (c == PadChar) begin
         r.pad = 1'b1;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/base64_stream_codec_unit.sv @@
// Base64 stream codec top level: input word register, group logic, result buffer.
// Depends on b64sc_pkg for the alphabet functions and buffer sizing.
//
// Streaming Base64 (standard alphabet, '=' padding). csr_wr_data selects
// decode (1) or encode (0); a write also clears any partial group. One input
// word can be taken every cycle unless a word with results waits for the
// result buffer to drain. A word that completes a group loads all of its
// results (four characters when encoding, up to three bytes when decoding,
// one error word on bad input) into a result buffer that drains one word per
// cycle while rsp_ready is high; this drain limits the sustained rate. The
// input word is registered, then its results are registered into the buffer.
module base64_stream_codec_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_bad_char
);

   localparam int unsigned CntW = b64sc_pkg::CountWidth;

   logic        mode_ff, mode_in;
   logic [23:0] group_bits_ff, group_bits_in;
   logic [1:0]  group_cnt_ff, group_cnt_in;
   logic [1:0]  pad_ff, pad_in;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_eom_ff;

   logic [7:0]  buf_ff [b64sc_pkg::MaxResults];
   logic [7:0]  buf_in [b64sc_pkg::MaxResults];
   logic [CntW-1:0] buf_cnt_ff, buf_cnt_in;
   logic        bad_ff, bad_in;

   logic        consume, buf_free, rsp_take;
   logic [CntW-1:0] res_cnt;
   logic [7:0]  res_byte [b64sc_pkg::MaxResults];
   logic        res_bad;

   logic [2:0]  enc_n;
   logic [23:0] enc_new, enc_sh;
   logic        enc_flush;

   b64sc_pkg::char_code_type cc;
   logic [2:0]  dec_p;
   logic [23:0] dec_new, dec_sh;
   logic [1:0]  dec_pad;
   logic        dec_flush, dec_err, dec_short;
   logic [3:0]  dec_data;

   assign rsp_take  = rsp_valid && rsp_ready;
   assign buf_free  = (buf_cnt_ff == '0) || (buf_cnt_ff == CntW'(1) && rsp_ready);
   assign consume   = in_valid_ff && ((res_cnt == '0) || buf_free);
   assign req_ready = !in_valid_ff || consume;

   assign rsp_valid    = buf_cnt_ff != '0;
   assign rsp_out_byte = buf_ff[0];
   assign rsp_run_last = buf_cnt_ff == CntW'(1);
   assign rsp_bad_char = bad_ff;

   // encode path
   always_comb begin
      enc_n     = {1'b0, group_cnt_ff} + 3'd1;
      enc_new   = {group_bits_ff[15:0], in_byte_ff};
      enc_flush = (enc_n >= 3'd3) || in_eom_ff;
      case (enc_n)
         3'd1:    enc_sh = {enc_new[7:0], 16'd0};
         3'd2:    enc_sh = {enc_new[15:0], 8'd0};
         default: enc_sh = enc_new;
      endcase
   end

   // decode path
   always_comb begin
      cc        = b64sc_pkg::char_decode(in_byte_ff);
      dec_p     = {1'b0, group_cnt_ff} + 3'd1;
      dec_new   = {group_bits_ff[17:0], cc.pad ? 6'd0 : cc.value};
      dec_pad   = pad_ff + {1'b0, cc.pad};
      dec_flush = (dec_p == 3'd4) || in_eom_ff;
      dec_err   = (!cc.alpha && !cc.pad) || (cc.pad && group_cnt_ff < 2'd2) ||
                  (cc.alpha && pad_ff != 2'd0);
      dec_data  = {1'b0, dec_p} - {2'b00, dec_pad};
      dec_short = (dec_data < 4'd2) || (dec_data > 4'd4);
      case (dec_p)
         3'd1:    dec_sh = {dec_new[5:0], 18'd0};
         3'd2:    dec_sh = {dec_new[11:0], 12'd0};
         3'd3:    dec_sh = {dec_new[17:0], 6'd0};
         default: dec_sh = dec_new;
      endcase
   end

   // results and next group state for the held word
   always_comb begin
      res_cnt       = '0;
      res_bad       = 1'b0;
      res_byte[0]   = 8'd0;
      res_byte[1]   = 8'd0;
      res_byte[2]   = 8'd0;
      res_byte[3]   = 8'd0;
      group_bits_in = group_bits_ff;
      group_cnt_in  = group_cnt_ff;
      pad_in        = pad_ff;
      if (!mode_ff) begin
         if (!enc_flush) begin
            group_bits_in = enc_new;
            group_cnt_in  = enc_n[1:0];
         end else begin
            res_cnt       = CntW'(4);
            res_byte[0]   = b64sc_pkg::sextet_to_char(enc_sh[23:18]);
            res_byte[1]   = b64sc_pkg::sextet_to_char(enc_sh[17:12]);
            res_byte[2]   = (enc_n >= 3'd2) ? b64sc_pkg::sextet_to_char(enc_sh[11:6])
                                            : b64sc_pkg::PadChar;
            res_byte[3]   = (enc_n >= 3'd3) ? b64sc_pkg::sextet_to_char(enc_sh[5:0])
                                            : b64sc_pkg::PadChar;
            group_bits_in = '0;
            group_cnt_in  = '0;
            pad_in        = '0;
         end
      end else begin
         if (dec_err || (dec_flush && dec_short)) begin
            res_cnt       = CntW'(1);
            res_bad       = 1'b1;
            group_bits_in = '0;
            group_cnt_in  = '0;
            pad_in        = '0;
         end else if (!dec_flush) begin
            group_bits_in = dec_new;
            group_cnt_in  = dec_p[1:0];
            pad_in        = dec_pad;
         end else begin
            res_cnt       = CntW'(dec_data[2:0] - 3'd1);
            res_byte[0]   = dec_sh[23:16];
            res_byte[1]   = dec_sh[15:8];
            res_byte[2]   = dec_sh[7:0];
            group_bits_in = '0;
            group_cnt_in  = '0;
            pad_in        = '0;
         end
      end
   end

   // result buffer: load on a producing word, else shift out one per take
   always_comb begin
      buf_in     = buf_ff;
      buf_cnt_in = buf_cnt_ff;
      bad_in     = bad_ff;
      if (consume && res_cnt != '0) begin
         buf_in     = res_byte;
         buf_cnt_in = res_cnt;
         bad_in     = res_bad;
      end else if (rsp_take) begin
         for (int i = 0; i < b64sc_pkg::MaxResults - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         buf_cnt_in = buf_cnt_ff - CntW'(1);
      end
   end

   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign mode_in     = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         group_bits_ff <= '0;
         group_cnt_ff  <= '0;
         pad_ff        <= '0;
         in_valid_ff   <= 1'b0;
         buf_cnt_ff    <= '0;
         bad_ff        <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         in_valid_ff <= in_valid_in;
         buf_cnt_ff  <= buf_cnt_in;
         bad_ff      <= bad_in;
         if (csr_wr_en) begin
            group_bits_ff <= '0;
            group_cnt_ff  <= '0;
            pad_ff        <= '0;
         end else if (consume) begin
            group_bits_ff <= group_bits_in;
            group_cnt_ff  <= group_cnt_in;
            pad_ff        <= pad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_eom_ff  <= req_end_of_message;
      end
      buf_ff <= buf_in;
   end

   a_bad_only_decode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_char |-> mode_ff && rsp_run_last)
      else $error("error word outside decode or not single");

   a_enc_group_bound: assert property (@(posedge clock) disable iff (reset)
      !mode_ff |-> group_cnt_ff != 2'd3 && pad_ff == 2'd0)
      else $error("encode group state out of range");

   a_pad_position: assert property (@(posedge clock) disable iff (reset)
      pad_ff != 2'd0 |-> group_cnt_ff >= 2'd3 || pad_ff == 2'd1 && group_cnt_ff == 2'd3 ||
                         group_cnt_ff == 2'd3)
      else $error("padding held in an early group position");

   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      buf_cnt_ff <= CntW'(b64sc_pkg::MaxResults))
      else $error("result buffer over capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      consume && res_cnt != '0 |-> buf_cnt_ff == '0 || (buf_cnt_ff == CntW'(1) && rsp_ready))
      else $error("result buffer overwritten before drained");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for base64_stream_codec_unit: directed table, then random messages.
// Holds its own Base64 translator of each input word; depends on b64sc_pkg and the RTL.
module tb_top;

   localparam logic ModeEncode = 1'b0;
   localparam logic ModeDecode = 1'b1;
   localparam int PadSextet = 64;
   localparam int NotAlphabet = 255;
   localparam int DirRows = 27;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       bad_char;
   } codec_word_type;

   localparam codec_word_type ErrorWord = {8'h00, 1'b1, 1'b1};

   typedef enum logic {RowData, RowMode} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      logic         eom;
      logic         bad;
   } dir_row_type;

   typedef enum {FlawRandomByte, FlawStrayPad, FlawLoneChar, FlawOpenEnd} text_flaw_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b1;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_bad_char;

   logic        mode_dec = ModeEncode;
   logic [23:0] grp_bits = '0;
   logic [1:0]  grp_count = '0;
   logic [1:0]  grp_pads = '0;

   codec_word_type owed_words[$];
   codec_word_type seen_word;
   codec_word_type want_word;
   int unsigned mismatch_count = 0;
   int unsigned words_sent = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   dir_row_type dir_rows [DirRows] = '{
      '{RowData, 8'h00, 1'b1, 1'b0},
      '{RowData, 8'hFF, 1'b0, 1'b0},
      '{RowData, 8'h00, 1'b1, 1'b0},
      '{RowData, 8'hFF, 1'b0, 1'b0},
      '{RowData, 8'hFF, 1'b0, 1'b0},
      '{RowData, 8'hFF, 1'b1, 1'b0},
      '{RowMode, 8'(ModeDecode), 1'b0, 1'b0},
      '{RowData, "/", 1'b0, 1'b0},
      '{RowData, "/", 1'b0, 1'b0},
      '{RowData, "/", 1'b0, 1'b0},
      '{RowData, "/", 1'b1, 1'b0},
      '{RowData, "A", 1'b0, 1'b0},
      '{RowData, "B", 1'b0, 1'b0},
      '{RowData, "=", 1'b0, 1'b0},
      '{RowData, "=", 1'b0, 1'b0},
      '{RowData, "A", 1'b0, 1'b0},
      '{RowData, "A", 1'b1, 1'b0},
      '{RowData, "A", 1'b1, 1'b1},
      '{RowData, 8'hFF, 1'b0, 1'b1},
      '{RowData, " ", 1'b0, 1'b1},
      '{RowData, "=", 1'b0, 1'b1},
      '{RowData, "A", 1'b0, 1'b0},
      '{RowData, "=", 1'b0, 1'b1},
      '{RowData, "A", 1'b0, 1'b0},
      '{RowData, "A", 1'b0, 1'b0},
      '{RowData, "=", 1'b0, 1'b0},
      '{RowData, "B", 1'b0, 1'b1}
   };

   base64_stream_codec_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_bad_char       (rsp_bad_char)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [7:0] alpha_char(input logic [5:0] s);
      return (s < 26) ? 8'h41 + s : (s < 52) ? 8'h47 + s : (s < 62) ? s - 8'd4 :
             (s == 62) ? "+" : "/";
   endfunction

   function automatic int sextet_of(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "a" && c <= "z") return c - "a" + 26;
      if (c >= "0" && c <= "9") return c - "0" + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      if (c == b64sc_pkg::PadChar) return PadSextet;
      return NotAlphabet;
   endfunction

   function automatic void clear_group();
      grp_bits = '0;
      grp_count = '0;
      grp_pads = '0;
   endfunction

   task automatic translate_item(input logic [7:0] b, input logic eom,
                                 ref codec_word_type words[$]);
      int n;
      int v;
      int data;
      logic [23:0] bits;
      words.delete();
      if (mode_dec == ModeEncode) begin
         n = grp_count + 1;
         grp_bits = {grp_bits[15:0], b};
         if (n < 3 && !eom) begin
            grp_count = 2'(n);
            return;
         end
         bits = grp_bits << (8 * (3 - n));
         for (int i = 0; i <= n; i++)
            words.push_back(codec_word_type'({alpha_char(bits[23 - 6 * i -: 6]), 2'b00}));
         for (int i = n; i < 3; i++)
            words.push_back(codec_word_type'({b64sc_pkg::PadChar, 2'b00}));
         clear_group();
      end else begin
         v = sextet_of(b);
         if (v == NotAlphabet || (v == PadSextet && grp_count < 2) ||
             (v < PadSextet && grp_pads != 0)) begin
            clear_group();
            words.push_back(ErrorWord);
            return;
         end
         grp_bits = {grp_bits[17:0], (v == PadSextet) ? 6'd0 : 6'(v)};
         if (v == PadSextet) grp_pads++;
         n = grp_count + 1;
         if (n < 4 && !eom) begin
            grp_count = 2'(n);
            return;
         end
         data = n - grp_pads;
         bits = grp_bits << (6 * (4 - n));
         clear_group();
         if (data < 2) begin
            words.push_back(ErrorWord);
            return;
         end
         for (int i = 0; i + 1 < data; i++)
            words.push_back(codec_word_type'({bits[23 - 8 * i -: 8], 2'b00}));
      end
      if (words.size() != 0) words[words.size() - 1].run_last = 1'b1;
   endtask

   task automatic push_word(input logic [7:0] b, input logic eom, input logic typed_err);
      codec_word_type made[$];
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_message <= eom;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      translate_item(b, eom, made);
      if (typed_err) owed_words.push_back(ErrorWord);
      else foreach (made[i]) owed_words.push_back(made[i]);
   endtask

   // drop valid, drain every owed word, then cover the pipeline latency
   task automatic settle();
      req_valid <= 1'b0;
      while (owed_words.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_dec = m;
      clear_group();
   endtask

   task automatic send_message();
      logic [7:0] txt[$];
      int len;
      int full_groups;
      int tail;
      int spot;
      text_flaw_type flaw;
      logic keep_eom;
      keep_eom = 1'b1;
      if (mode_dec == ModeEncode) begin
         len = $urandom_range(9, 1);
         repeat (len)
            txt.push_back(($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00) :
                          8'($urandom_range(255)));
         keep_eom = ($urandom_range(9) != 0);
      end else begin
         full_groups = $urandom_range(2);
         tail = $urandom_range(2);
         if (tail != 0) tail++;
         if (full_groups == 0 && tail == 0) tail = 2;
         repeat (4 * full_groups + tail) txt.push_back(alpha_char(6'($urandom_range(63))));
         if (tail != 0 && $urandom_range(1) == 1)
            repeat (4 - tail) txt.push_back(b64sc_pkg::PadChar);
         if ($urandom_range(99) < 25) begin
            flaw = text_flaw_type'($urandom_range(3));
            spot = $urandom_range(txt.size() - 1);
            case (flaw)
               FlawRandomByte: begin
                  txt[spot] = 8'($urandom_range(255));
               end
               FlawStrayPad: begin
                  txt.insert(spot, b64sc_pkg::PadChar);
               end
               FlawLoneChar: begin
                  while (txt.size() % 4 != 1) void'(txt.pop_back());
               end
               default: begin
                  keep_eom = 1'b0;
               end
            endcase
         end
      end
      foreach (txt[i]) push_word(txt[i], keep_eom && (i == txt.size() - 1), 1'b0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_word = {rsp_out_byte, rsp_run_last, rsp_bad_char};
         if (owed_words.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word byte=%h last=%b bad=%b", $time,
                     seen_word.out_byte, seen_word.run_last, seen_word.bad_char);
         end else begin
            want_word = owed_words.pop_front();
            if (seen_word !== want_word) begin
               mismatch_count++;
               $display("%0t: expected byte=%h last=%b bad=%b, actual byte=%h last=%b bad=%b",
                        $time, want_word.out_byte, want_word.run_last, want_word.bad_char,
                        seen_word.out_byte, seen_word.run_last, seen_word.bad_char);
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      int unsigned send_pcts [3];
      int unsigned recv_pcts [3];
      int unsigned target;
      logic pick;
      send_pcts = '{34, 53, 0};
      recv_pcts = '{53, 34, 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = send_pcts[0];
      recv_idle_pct = recv_pcts[0];
      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == RowMode) begin
            settle();
            write_mode(dir_rows[r].value[0]);
         end else begin
            push_word(dir_rows[r].value, dir_rows[r].eom, dir_rows[r].bad);
         end
      end
      settle();
      write_mode(ModeEncode);
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = send_pcts[ph];
         recv_idle_pct = recv_pcts[ph];
         target = words_sent + 100;
         while (words_sent < target) begin
            pick = $urandom_range(1);
            if (pick != mode_dec || $urandom_range(3) == 0) begin
               settle();
               write_mode(pick);
            end
            send_message();
         end
      end
      settle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
